// File: hw/rtl/binary_morphology_3x3_defines.svh
// Assertion macros for the RTL of the morphology block.
`ifndef BINARY_MORPHOLOGY_3X3_DEFINES_SVH
`define BINARY_MORPHOLOGY_3X3_DEFINES_SVH

// Checked at every clock edge outside reset.
`define BM3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every clock edge, reset included.
`define BM3_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/bm3_pkg.sv
package bm3_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  localparam int unsigned COL_W    = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W    = $clog2(MAX_HEIGHT);
  localparam int unsigned DIM_W    = 11;
  localparam int unsigned FILL_W   = $clog2(MAX_WIDTH + 2);
  localparam int unsigned FLIGHT_W = $clog2(2 * MAX_WIDTH + 3);
  localparam int unsigned PIX_W    = 8;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_OPERATION_MODE = 2'd2
  } bm3_reg_e;

  typedef enum logic [1:0] {
    MODE_EROSION = 2'd0,
    MODE_DILATION = 2'd1,
    MODE_OPENING = 2'd2,
    MODE_CLOSING = 2'd3
  } bm3_mode_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } bm3_cmd_e;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } bm3_pos_t;

  // Line memory read issued for the item that enters a pass stage.
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
  } bm3_rd_t;

  // Item held in a pass stage.
  typedef struct packed {
    logic             push;
    logic [COL_W-1:0] addr;
    logic             border;
    logic             use_or;
  } bm3_slot_t;

  function automatic bm3_pos_t pos_advance(bm3_pos_t p, logic [DIM_W-1:0] fw,
                                           logic [DIM_W-1:0] fh);
    bm3_pos_t r;
    r = p;
    if (DIM_W'(p.col) + DIM_W'(1) >= fw) begin
      r.col = '0;
      if (DIM_W'(p.row) + DIM_W'(1) >= fh) begin
        r.row = '0;
      end else begin
        r.row = ROW_W'(p.row + ROW_W'(1));
      end
    end else begin
      r.col = COL_W'(p.col + COL_W'(1));
    end
    return r;
  endfunction

  function automatic logic pos_border(bm3_pos_t p, logic [DIM_W-1:0] fw,
                                      logic [DIM_W-1:0] fh);
    return (p.row == '0) || (DIM_W'(p.row) >= fh - DIM_W'(1)) ||
           (p.col == '0) || (DIM_W'(p.col) >= fw - DIM_W'(1));
  endfunction

endpackage

// File: hw/rtl/binary_morphology_3x3.sv
// 3x3 binary morphology on a raster pixel stream: erosion, dilation, opening
// or closing, with the border rows and columns of every pass copied through.
// The block takes one pixel per clock and gives one result per clock once it
// is full, while the output is not stalled; each pass delays the stream by
// frame_width+1 pixels, on top of the s1, s2 and output registers. The rate is
// set by one read and one write per cycle on each pass's line memory, a
// 1024 x 16-bit store holding the two previous rows. The line memories are not
// cleared after reset; their stale contents never reach a result. After the last
// pixel of a frame, drain transfers push out the pixels still in flight, and
// the stream then restarts empty. Any register write also restarts the stream.
`include "binary_morphology_3x3_defines.svh"

module binary_morphology_3x3 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // pixel_in
  input  logic [0:0]  s_axis_tuser_i,   // command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // pixel_out
  output logic [0:0]  m_axis_tuser_o,   // row_end
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bm3_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    bm3_slot_t        slot0;
    bm3_slot_t        slot1;
    logic             got;
    logic             rend;
    logic             fend;
  } s1_t;

  typedef struct packed {
    logic [PIX_W-1:0] res0;
    bm3_slot_t        slot1;
    logic             got;
    logic             rend;
    logic             fend;
  } s2_t;

  logic [DIM_W-1:0]    fw_q, fh_q;
  bm3_mode_e           mode_q;
  logic [DIM_W-1:0]    cfg_dim;
  logic                cfg_wr;
  bm3_reg_e            cfg_reg;

  bm3_pos_t            in0_q, in0_d, out0_q, out0_d;
  bm3_pos_t            in1_q, in1_d, out1_q, out1_d;
  logic [FILL_W-1:0]   fill0_q, fill0_d, fill1_q, fill1_d;
  logic [FLIGHT_W-1:0] in_flight_q, in_flight_d;
  logic                draining_q, draining_d;

  s1_t                 s1_q, s1_d;
  s2_t                 s2_q, s2_d;
  logic                out_valid_q;
  logic [PIX_W-1:0]    out_pix_q;
  logic                out_rend_q, out_fend_q;

  logic                adv;
  logic                accept;
  logic                take_data, take_drain;
  logic                first_or, two_pass;
  logic                got0, got1;
  logic [FILL_W-1:0]   fill_full;
  logic [FLIGHT_W-1:0] flight;
  logic [PIX_W-1:0]    res0, res1;
  bm3_rd_t             rd0, rd1;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_reg = bm3_reg_e'(paddr[3:2]);

  always_comb begin
    cfg_dim = pwdata[DIM_W-1:0];
    if (cfg_dim < DIM_W'(3)) begin
      cfg_dim = DIM_W'(3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= DIM_W'(640);
      fh_q   <= DIM_W'(480);
      mode_q <= MODE_EROSION;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        REG_FRAME_WIDTH: begin
          fw_q <= (cfg_dim > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : cfg_dim;
        end
        REG_FRAME_HEIGHT: begin
          fh_q <= (cfg_dim > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg_dim;
        end
        REG_OPERATION_MODE: begin
          mode_q <= bm3_mode_e'(pwdata[1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_FRAME_WIDTH:    prdata = 32'(fw_q);
      REG_FRAME_HEIGHT:   prdata = 32'(fh_q);
      REG_OPERATION_MODE: prdata = 32'(mode_q);
      default:            prdata = '0;
    endcase
  end

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign accept          = s_axis_tvalid_i && adv;
  assign first_or        = (mode_q == MODE_DILATION) || (mode_q == MODE_CLOSING);
  assign two_pass        = (mode_q == MODE_OPENING) || (mode_q == MODE_CLOSING);
  assign fill_full       = FILL_W'(fw_q) + FILL_W'(1);

  assign take_data  = !draining_q && (bm3_cmd_e'(s_axis_tuser_i[0]) == CMD_PIXEL);
  assign take_drain = !take_data &&
                      (draining_q || ((in0_q == '0) && (in_flight_q != '0)));

  always_comb begin
    in0_d       = in0_q;
    out0_d      = out0_q;
    in1_d       = in1_q;
    out1_d      = out1_q;
    fill0_d     = fill0_q;
    fill1_d     = fill1_q;
    in_flight_d = in_flight_q;
    draining_d  = draining_q;
    s1_d        = '0;
    got0        = 1'b0;
    got1        = 1'b0;
    flight      = in_flight_q;

    if (cfg_wr && (cfg_reg == REG_FRAME_WIDTH || cfg_reg == REG_FRAME_HEIGHT ||
                   cfg_reg == REG_OPERATION_MODE)) begin
      in0_d       = '0;
      out0_d      = '0;
      in1_d       = '0;
      out1_d      = '0;
      fill0_d     = '0;
      fill1_d     = '0;
      in_flight_d = '0;
      draining_d  = 1'b0;
    end else if (accept && (take_data || take_drain)) begin
      flight           = FLIGHT_W'(in_flight_q + FLIGHT_W'(take_data));
      s1_d.pix         = take_data ? s_axis_tdata_i : '0;
      s1_d.slot0.push  = 1'b1;
      s1_d.slot0.addr  = in0_q.col;
      s1_d.slot0.use_or = first_or;
      in0_d            = pos_advance(in0_q, fw_q, fh_q);
      got0             = (fill0_q == fill_full);
      if (!got0) begin
        fill0_d = FILL_W'(fill0_q + FILL_W'(1));
      end else begin
        s1_d.slot0.border = pos_border(out0_q, fw_q, fh_q);
        s1_d.rend = (DIM_W'(out0_q.col) >= fw_q - DIM_W'(1));
        s1_d.fend = s1_d.rend && (DIM_W'(out0_q.row) >= fh_q - DIM_W'(1));
        out0_d    = pos_advance(out0_q, fw_q, fh_q);
      end
      s1_d.got = got0;
      if (got0 && two_pass) begin
        s1_d.slot1.push   = 1'b1;
        s1_d.slot1.addr   = in1_q.col;
        s1_d.slot1.use_or = !first_or;
        in1_d             = pos_advance(in1_q, fw_q, fh_q);
        got1              = (fill1_q == fill_full);
        if (!got1) begin
          fill1_d  = FILL_W'(fill1_q + FILL_W'(1));
          s1_d.got = 1'b0;
        end else begin
          s1_d.slot1.border = pos_border(out1_q, fw_q, fh_q);
          s1_d.rend = (DIM_W'(out1_q.col) >= fw_q - DIM_W'(1));
          s1_d.fend = s1_d.rend && (DIM_W'(out1_q.row) >= fh_q - DIM_W'(1));
          out1_d    = pos_advance(out1_q, fw_q, fh_q);
        end
      end
      if (s1_d.got && (flight != '0)) begin
        flight = FLIGHT_W'(flight - FLIGHT_W'(1));
      end
      in_flight_d = flight;
      if (take_drain) begin
        draining_d = 1'b1;
      end
      if (s1_d.got && draining_d && (flight == '0)) begin
        in0_d       = '0;
        out0_d      = '0;
        in1_d       = '0;
        out1_d      = '0;
        fill0_d     = '0;
        fill1_d     = '0;
        in_flight_d = '0;
        draining_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in0_q       <= '0;
      out0_q      <= '0;
      in1_q       <= '0;
      out1_q      <= '0;
      fill0_q     <= '0;
      fill1_q     <= '0;
      in_flight_q <= '0;
      draining_q  <= 1'b0;
    end else begin
      in0_q       <= in0_d;
      out0_q      <= out0_d;
      in1_q       <= in1_d;
      out1_q      <= out1_d;
      fill0_q     <= fill0_d;
      fill1_q     <= fill1_d;
      in_flight_q <= in_flight_d;
      draining_q  <= draining_d;
    end
  end

  assign rd0.en   = s1_d.slot0.push;
  assign rd0.addr = s1_d.slot0.addr;
  assign rd1.en   = s1_q.slot1.push;
  assign rd1.addr = s1_q.slot1.addr;

  bm3_pass u_pass0 (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .rd_i   (rd0),
    .slot_i (s1_q.slot0),
    .pix_i  (s1_q.pix),
    .res_o  (res0)
  );

  bm3_pass u_pass1 (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .rd_i   (rd1),
    .slot_i (s2_q.slot1),
    .pix_i  (s2_q.res0),
    .res_o  (res1)
  );

  always_comb begin
    s2_d.res0  = res0;
    s2_d.slot1 = s1_q.slot1;
    s2_d.got   = s1_q.got;
    s2_d.rend  = s1_q.rend;
    s2_d.fend  = s1_q.fend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_q        <= s1_d;
      s2_q        <= s2_d;
      out_valid_q <= s2_q.got;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pix_q  <= s2_q.slot1.push ? res1 : s2_q.res0;
      out_rend_q <= s2_q.rend;
      out_fend_q <= s2_q.fend;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_pix_q;
  assign m_axis_tuser_o[0] = out_rend_q;
  assign m_axis_tlast_o    = out_fend_q;

  `BM3_ASSERT(a_drain_pending, draining_q |-> (in_flight_q != '0),
              "Draining with no pixels in flight.")
  `BM3_ASSERT(a_pass1_mode,
              s2_q.slot1.push |-> (mode_q == MODE_OPENING || mode_q == MODE_CLOSING),
              "Second pass pushed outside opening or closing.")
  `BM3_ASSERT(a_frame_end_row_end, (m_axis_tvalid_o && m_axis_tlast_o) |-> m_axis_tuser_o[0],
              "Frame end without row end.")
  `BM3_ASSERT(a_stall_holds, !adv |=> $stable(s1_q) && $stable(s2_q),
              "Pipeline moved during a stall.")
  `BM3_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid_o,
                     "Result offered straight after reset.")

endmodule

// File: hw/rtl/bm3_pass.sv
module bm3_pass (
  input  logic                     clk_i,
  input  logic                     adv_i,
  input  bm3_pkg::bm3_rd_t         rd_i,
  input  bm3_pkg::bm3_slot_t       slot_i,
  input  logic [bm3_pkg::PIX_W-1:0] pix_i,
  output logic [bm3_pkg::PIX_W-1:0] res_o
);
  import bm3_pkg::*;

  // Upper byte: line two rows up, lower byte: line one row up.
  logic [2*PIX_W-1:0] line_mem_q [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;
  logic [PIX_W-1:0]   win_q [9];
  logic [PIX_W-1:0]   win_d [9];
  logic [PIX_W-1:0]   and_v;
  logic [PIX_W-1:0]   or_v;

  always_ff @(posedge clk_i) begin
    if (adv_i && rd_i.en) begin
      rd_q <= line_mem_q[rd_i.addr];
    end
    if (adv_i && slot_i.push) begin
      line_mem_q[slot_i.addr] <= {rd_q[PIX_W-1:0], pix_i};
    end
  end

  always_comb begin
    for (int y = 0; y < 3; y++) begin
      win_d[3*y]     = win_q[3*y + 1];
      win_d[3*y + 1] = win_q[3*y + 2];
    end
    win_d[2] = rd_q[2*PIX_W-1:PIX_W];
    win_d[5] = rd_q[PIX_W-1:0];
    win_d[8] = pix_i;
    and_v = '1;
    or_v  = '0;
    for (int k = 0; k < 9; k++) begin
      and_v = and_v & win_d[k];
      or_v  = or_v | win_d[k];
    end
    if (slot_i.border) begin
      res_o = win_d[4];
    end else if (slot_i.use_or) begin
      res_o = or_v;
    end else begin
      res_o = and_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && slot_i.push) begin
      win_q <= win_d;
    end
  end

endmodule
